// File: hw/rtl/dttk_pkg.sv
// ----------------------------------------------------------------------------
// dttk_pkg
// shared constants, register codes and queue entry layout of the
// detection threshold and top-k filter
// ----------------------------------------------------------------------------
package dttk_pkg;

    localparam int DEF_MAX_DETS    = 64;
    localparam int DEF_CONF_BITS   = 16;
    localparam int DEF_NUM_CLASSES = 64;

    localparam int CONF_IN_BITS    = 16;
    localparam int CLASS_BITS      = 6;
    localparam int DET_INDEX_BITS  = 6;
    localparam int MAX_KEEP_BITS   = 7;
    localparam int CLASS_MASK_BITS = 64;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 64;
    localparam int WIDE_BITS       = 32;

    localparam int QUEUE_DEPTH     = 4;

    // queue entry layout: {conf, pass, nonempty, last}
    localparam int ENTRY_LAST      = 0;
    localparam int ENTRY_NONEMPTY  = 1;
    localparam int ENTRY_PASS      = 2;
    localparam int ENTRY_CONF      = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_MAX_KEEP   = 2'd1,
        REG_CLASS_ON   = 2'd2,
        REG_CLASS_MASK = 2'd3
    } cfg_reg_t;

endpackage

// File: hw/rtl/dttk_front.sv
// ----------------------------------------------------------------------------
// dttk_front
// configuration registers and per-detection classification: threshold and
// class test, packed into a queue entry
// ----------------------------------------------------------------------------
module dttk_front
    import dttk_pkg::*;
#(
    parameter int CONF_BITS   = DEF_CONF_BITS,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CONF_IN_BITS-1:0]       confidence,
    input  logic [CLASS_BITS-1:0]         class_id,
    input  logic                          box_empty,
    input  logic                          frame_last,
    input  logic                          queue_full,
    output logic                          push,
    output logic [CONF_BITS+ENTRY_CONF-1:0] push_entry,
    output logic [MAX_KEEP_BITS-1:0]      max_keep
);

    logic [CONF_IN_BITS-1:0]    thr_reg, thr_next;
    logic [MAX_KEEP_BITS-1:0]   max_keep_reg, max_keep_next;
    logic                       class_on_reg, class_on_next;
    logic [CLASS_MASK_BITS-1:0] class_mask_reg, class_mask_next;

    logic [WIDE_BITS-1:0]       conf_wide;
    logic [WIDE_BITS-1:0]       thr_wide;
    logic [CONF_BITS-1:0]       conf;
    logic [CONF_BITS-1:0]       thr;
    logic                       class_ok;
    logic                       pass;

    always_comb
    begin
        thr_next        = thr_reg;
        max_keep_next   = max_keep_reg;
        class_on_next   = class_on_reg;
        class_mask_next = class_mask_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:  thr_next        = cfg_data[CONF_IN_BITS-1:0];
                REG_MAX_KEEP:   max_keep_next   = cfg_data[MAX_KEEP_BITS-1:0];
                REG_CLASS_ON:   class_on_next   = cfg_data[0];
                REG_CLASS_MASK: class_mask_next = cfg_data[CLASS_MASK_BITS-1:0];
                default:        thr_next        = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= '0;
            max_keep_reg   <= '0;
            class_on_reg   <= 1'b0;
            class_mask_reg <= '0;
        end
        else
        begin
            thr_reg        <= thr_next;
            max_keep_reg   <= max_keep_next;
            class_on_reg   <= class_on_next;
            class_mask_reg <= class_mask_next;
        end
    end

    always_comb
    begin
        conf_wide = WIDE_BITS'(confidence);
        thr_wide  = WIDE_BITS'(thr_reg);
        conf      = conf_wide[CONF_BITS-1:0];
        thr       = thr_wide[CONF_BITS-1:0];
        class_ok  = !class_on_reg || (class_mask_reg == '0) ||
                    (((CLASS_BITS+1)'(class_id) < (CLASS_BITS+1)'(NUM_CLASSES)) &&
                     class_mask_reg[class_id]);
        pass      = (conf >= thr) && class_ok;
    end

    assign in_stall   = queue_full;
    assign push       = in_valid && !queue_full;
    assign push_entry = {conf, pass, !box_empty, frame_last};
    assign max_keep   = max_keep_reg;

endmodule

// File: hw/rtl/dttk_queue.sv
// ----------------------------------------------------------------------------
// dttk_queue
// short fifo of classified detections between front and back
// ----------------------------------------------------------------------------
module dttk_queue
    import dttk_pkg::*;
#(
    parameter int WIDTH = DEF_CONF_BITS + ENTRY_CONF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

endmodule

// File: hw/rtl/dttk_back.sv
// ----------------------------------------------------------------------------
// dttk_back
// detection store, top-k cut search and in-order keep emission
// ----------------------------------------------------------------------------
module dttk_back
    import dttk_pkg::*;
#(
    parameter int MAX_DETS  = DEF_MAX_DETS,
    parameter int CONF_BITS = DEF_CONF_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [MAX_KEEP_BITS-1:0]      max_keep,
    input  logic                          q_empty,
    input  logic [CONF_BITS+ENTRY_CONF-1:0] q_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [DET_INDEX_BITS-1:0]     det_index,
    output logic                          keep,
    output logic                          overflow,
    output logic                          result_last
);

    localparam int IDX_W = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
    localparam int CNT_W = $clog2(MAX_DETS + 1);
    localparam int CMP_W = (CNT_W > MAX_KEEP_BITS) ? CNT_W : MAX_KEEP_BITS;
    localparam int BIT_W = $clog2(CONF_BITS);
    localparam int MEM_W = CONF_BITS + 2;

    typedef enum logic [3:0] {
        S_COLLECT = 4'b0001,
        S_SEARCH  = 4'b0010,
        S_TIE     = 4'b0100,
        S_EMIT    = 4'b1000
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     det_count_reg, det_count_next;
    logic [CNT_W-1:0]     comp_count_reg, comp_count_next;
    logic                 overflow_seen_reg, overflow_seen_next;
    logic                 limit_reg, limit_next;
    logic [CONF_BITS-1:0] cut_reg, cut_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [CNT_W-1:0]     hit_count_reg, hit_count_next;
    logic [CMP_W-1:0]     quota_reg, quota_next;
    logic [IDX_W-1:0]     issue_ptr_reg, issue_ptr_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic                 rd_last_reg, rd_last_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [MEM_W-1:0]     rd_data_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_idx_reg, out_idx_next;
    logic                 out_keep_reg, out_keep_next;
    logic                 out_ovf_reg, out_ovf_next;
    logic                 out_last_reg, out_last_next;

    logic [MEM_W-1:0]     store_mem [MAX_DETS];

    logic                 q_last;
    logic                 q_comp;
    logic                 room;
    logic [CNT_W-1:0]     comp_new;
    logic                 wr_en;
    logic                 rd_en;
    logic                 d_ne;
    logic                 d_pass;
    logic                 d_comp;
    logic [CONF_BITS-1:0] d_conf;
    logic [CONF_BITS-1:0] cand;
    logic                 hit;
    logic [CNT_W-1:0]     hit_sum;
    logic [CMP_W-1:0]     k;
    logic                 out_free;
    logic                 ptr_last;
    logic                 take_tie;
    logic                 keep_v;
    logic [IDX_W+DET_INDEX_BITS-1:0] idx_wide;

    always_comb
    begin
        q_last   = q_data[ENTRY_LAST];
        q_comp   = q_data[ENTRY_PASS] && q_data[ENTRY_NONEMPTY];
        room     = det_count_reg < CNT_W'(MAX_DETS);
        pop      = (state_reg == S_COLLECT) && !q_empty;
        wr_en    = pop && room;
        comp_new = comp_count_reg + CNT_W'(q_comp && room);

        d_ne     = rd_data_reg[0];
        d_pass   = rd_data_reg[1];
        d_conf   = rd_data_reg[2 +: CONF_BITS];
        d_comp   = d_pass && d_ne;
        cand     = cut_reg | (CONF_BITS'(1) << bit_reg);
        hit      = (state_reg == S_SEARCH) ? (d_comp && (d_conf >= cand))
                                           : (d_comp && (d_conf > cut_reg));
        hit_sum  = hit_count_reg + CNT_W'(hit);
        k        = CMP_W'(max_keep);
        out_free = !out_valid_reg || !out_stall;
        ptr_last = CNT_W'(issue_ptr_reg) == (det_count_reg - CNT_W'(1));

        take_tie = limit_reg && d_comp && (d_conf == cut_reg) && (quota_reg != '0);
        keep_v   = d_pass && !(limit_reg && d_ne && !((d_conf > cut_reg) || take_tie));

        rd_en = (((state_reg == S_SEARCH) || (state_reg == S_TIE)) && !issue_done_reg) ||
                ((state_reg == S_EMIT) && !issue_done_reg && !rd_vld_reg && out_free);
    end

    always_comb
    begin
        state_next         = state_reg;
        det_count_next     = det_count_reg;
        comp_count_next    = comp_count_reg;
        overflow_seen_next = overflow_seen_reg;
        limit_next         = limit_reg;
        cut_next           = cut_reg;
        bit_next           = bit_reg;
        hit_count_next     = hit_count_reg;
        quota_next         = quota_reg;
        issue_ptr_next     = issue_ptr_reg;
        issue_done_next    = issue_done_reg;
        rd_vld_next        = rd_en;
        rd_last_next       = rd_last_reg;
        rd_idx_next        = rd_idx_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_idx_next       = out_idx_reg;
        out_keep_next      = out_keep_reg;
        out_ovf_next       = out_ovf_reg;
        out_last_next      = out_last_reg;

        if (rd_en)
        begin
            issue_ptr_next  = issue_ptr_reg + IDX_W'(1);
            issue_done_next = ptr_last;
            rd_last_next    = ptr_last;
            rd_idx_next     = issue_ptr_reg;
        end

        unique case (state_reg)
            S_COLLECT:
            begin
                if (pop)
                begin
                    if (room)
                    begin
                        det_count_next  = det_count_reg + CNT_W'(1);
                        comp_count_next = comp_new;
                    end
                    else
                    begin
                        overflow_seen_next = 1'b1;
                    end
                    if (q_last)
                    begin
                        limit_next      = (k != '0) && (CMP_W'(comp_new) > k);
                        cut_next        = '0;
                        bit_next        = BIT_W'(CONF_BITS - 1);
                        hit_count_next  = '0;
                        issue_ptr_next  = '0;
                        issue_done_next = 1'b0;
                        state_next      = ((k != '0) && (CMP_W'(comp_new) > k)) ?
                                          S_SEARCH : S_EMIT;
                    end
                end
            end
            S_SEARCH:
            begin
                if (rd_vld_reg)
                begin
                    hit_count_next = hit_sum;
                    if (rd_last_reg)
                    begin
                        if (CMP_W'(hit_sum) >= k)
                        begin
                            cut_next = cand;
                        end
                        hit_count_next  = '0;
                        issue_ptr_next  = '0;
                        issue_done_next = 1'b0;
                        if (bit_reg == '0)
                        begin
                            state_next = S_TIE;
                        end
                        else
                        begin
                            bit_next = bit_reg - BIT_W'(1);
                        end
                    end
                end
            end
            S_TIE:
            begin
                if (rd_vld_reg)
                begin
                    hit_count_next = hit_sum;
                    if (rd_last_reg)
                    begin
                        quota_next      = k - CMP_W'(hit_sum);
                        hit_count_next  = '0;
                        issue_ptr_next  = '0;
                        issue_done_next = 1'b0;
                        state_next      = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (rd_vld_reg)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = rd_idx_reg;
                    out_keep_next  = keep_v;
                    out_ovf_next   = overflow_seen_reg;
                    out_last_next  = rd_last_reg;
                    if (take_tie)
                    begin
                        quota_next = quota_reg - CMP_W'(1);
                    end
                    if (rd_last_reg)
                    begin
                        det_count_next     = '0;
                        comp_count_next    = '0;
                        overflow_seen_next = 1'b0;
                        issue_ptr_next     = '0;
                        issue_done_next    = 1'b0;
                        state_next         = S_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_COLLECT;
            det_count_reg     <= '0;
            comp_count_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            limit_reg         <= 1'b0;
            cut_reg           <= '0;
            bit_reg           <= '0;
            hit_count_reg     <= '0;
            quota_reg         <= '0;
            issue_ptr_reg     <= '0;
            issue_done_reg    <= 1'b0;
            rd_vld_reg        <= 1'b0;
            rd_last_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            det_count_reg     <= det_count_next;
            comp_count_reg    <= comp_count_next;
            overflow_seen_reg <= overflow_seen_next;
            limit_reg         <= limit_next;
            cut_reg           <= cut_next;
            bit_reg           <= bit_next;
            hit_count_reg     <= hit_count_next;
            quota_reg         <= quota_next;
            issue_ptr_reg     <= issue_ptr_next;
            issue_done_reg    <= issue_done_next;
            rd_vld_reg        <= rd_vld_next;
            rd_last_reg       <= rd_last_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        out_idx_reg  <= out_idx_next;
        out_keep_reg <= out_keep_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    // detection store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[det_count_reg[IDX_W-1:0]] <= q_data[CONF_BITS+ENTRY_CONF-1:1];
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[issue_ptr_reg];
        end
    end

    assign idx_wide    = {{DET_INDEX_BITS{1'b0}}, out_idx_reg};
    assign out_valid   = out_valid_reg;
    assign det_index   = idx_wide[DET_INDEX_BITS-1:0];
    assign keep        = out_keep_reg;
    assign overflow    = out_ovf_reg;
    assign result_last = out_last_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        det_count_reg <= CNT_W'(MAX_DETS))
        else $error("detection count beyond capacity");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && rd_vld_reg) |-> !out_valid_reg)
        else $error("result loaded over a pending transaction");

    a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && rd_vld_reg && rd_last_reg) |=>
        ((state_reg == S_COLLECT) && (det_count_reg == '0) && !overflow_seen_reg))
        else $error("frame state not cleared after last result");

    a_quota_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && limit_reg) |-> (quota_reg <= k))
        else $error("tie quota above limit");

endmodule

// File: hw/rtl/detection_threshold_topk_filter.sv
// ----------------------------------------------------------------------------
// detection_threshold_topk_filter
// per-frame confidence threshold and top-k detection filter
// ----------------------------------------------------------------------------
// Detections are accepted one per cycle, while the queue is not full, into a
// four-entry queue and moved into the detection store at one per cycle while
// the back end collects. On the last detection of a frame of n stored
// detections the block emits n results through the single read port of the
// detection store, issuing the next read only when the previous result has
// been loaded and the output register is free. When a nonzero max_keep is
// exceeded by the passing non-empty detections, the cut is found first by
// CONF_BITS+1 scans of the store. Detections of the next frame are queued
// while results drain.
module detection_threshold_topk_filter
    import dttk_pkg::*;
#(
    parameter int MAX_DETS    = DEF_MAX_DETS,
    parameter int CONF_BITS   = DEF_CONF_BITS,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [CONF_IN_BITS-1:0]   confidence,
    input  logic [CLASS_BITS-1:0]     class_id,
    input  logic                      box_empty,
    input  logic                      frame_last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [DET_INDEX_BITS-1:0] det_index,
    output logic                      keep,
    output logic                      overflow,
    output logic                      result_last
);

    localparam int ENTRY_W = CONF_BITS + ENTRY_CONF;

    logic                     push;
    logic [ENTRY_W-1:0]       push_entry;
    logic                     queue_full;
    logic                     queue_empty;
    logic                     pop;
    logic [ENTRY_W-1:0]       pop_entry;
    logic [MAX_KEEP_BITS-1:0] max_keep;

    dttk_front #(
        .CONF_BITS   (CONF_BITS),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .confidence (confidence),
        .class_id   (class_id),
        .box_empty  (box_empty),
        .frame_last (frame_last),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry),
        .max_keep   (max_keep)
    );

    dttk_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_entry),
        .empty     (queue_empty)
    );

    dttk_back #(
        .MAX_DETS  (MAX_DETS),
        .CONF_BITS (CONF_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_keep    (max_keep),
        .q_empty     (queue_empty),
        .q_data      (pop_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .det_index   (det_index),
        .keep        (keep),
        .overflow    (overflow),
        .result_last (result_last)
    );

endmodule
